// ===== sv/tcb_pkg.sv =====
// Shared types and constants for the tensor contraction with bias block.
`default_nettype none

package tcb_pkg;

    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int DIM_W       = 6;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MAC  = 1'b1
    } t_op;

    typedef enum logic {
        REG_INNER_ROWS = 1'b0,
        REG_INNER_COLS = 1'b1
    } t_reg_idx;

    // Request held between the weight read and the multiplier.
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] bias;
    } t_s1;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             clamp;
    } t_sat;

endpackage

`default_nettype wire

// ===== sv/tcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcb_front.sv =====
// Front end: dimension registers, grid position, weight store and read stage.
`default_nettype none

module tcb_front #(
    parameter int MAX_ROWS = tcb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tcb_pkg::MAX_COLS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [tcb_pkg::DIM_W-1:0]        i_cfg_data,
    input  wire logic                             i_accept,
    input  wire logic                             i_op,
    input  wire logic [tcb_pkg::ADDR_W-1:0]       i_weight_index,
    input  wire logic signed [tcb_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [tcb_pkg::DATA_W-1:0] i_bias,
    input  wire logic                             i_s1_take,
    output tcb_pkg::t_s1                          o_s1,
    output logic [tcb_pkg::DATA_W-1:0]            o_weight
);
    import tcb_pkg::*;

    logic [DIM_W-1:0]  r_rows, r_cols, r_row, r_col;
    logic [DIM_W-1:0]  n_row, n_col;
    logic [DIM_W:0]    col_inc, row_inc;
    logic              wrap, last, mac_acc, load_acc;
    logic [2*DIM_W-1:0] addr_full;
    logic [ADDR_W-1:0] rd_addr;
    t_s1               r_s1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d, input int maxv);
        logic [DIM_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = DIM_W'(1);
        end
        if ({{(32-DIM_W){1'b0}}, res} > 32'(maxv)) begin
            res = DIM_W'(maxv);
        end
        return res;
    endfunction

    assign mac_acc  = i_accept && (i_op == OP_MAC);
    assign load_acc = i_accept && (i_op == OP_LOAD);

    assign col_inc = {1'b0, r_col} + (DIM_W+1)'(1);
    assign wrap    = col_inc >= {1'b0, r_cols};
    assign row_inc = wrap ? ({1'b0, r_row} + (DIM_W+1)'(1)) : {1'b0, r_row};
    assign last    = row_inc >= {1'b0, r_rows};

    always_comb begin
        if (last) begin
            n_row = '0;
            n_col = '0;
        end else begin
            n_row = row_inc[DIM_W-1:0];
            n_col = wrap ? '0 : col_inc[DIM_W-1:0];
        end
    end

    assign addr_full = r_row * r_cols + {{DIM_W{1'b0}}, r_col};
    assign rd_addr   = addr_full[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(1);
            r_cols <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_INNER_ROWS: r_rows <= clamp_dim(i_cfg_data, MAX_ROWS);
                REG_INNER_COLS: r_cols <= clamp_dim(i_cfg_data, MAX_COLS);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (mac_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (mac_acc) begin
                r_s1.valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1.valid <= 1'b0;
            end
        end
        if (mac_acc) begin
            r_s1.last <= last;
            r_s1.elem <= i_value;
            r_s1.bias <= i_bias;
        end
    end

    tcb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_DEPTH)
    ) u_weights (
        .i_clk  (i_clk),
        .i_we   (load_acc),
        .i_waddr(i_weight_index),
        .i_wdata(i_value),
        .i_re   (mac_acc),
        .i_raddr(rd_addr),
        .o_rdata(o_weight)
    );

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// ===== sv/tcb_back.sv =====
// Back end: multiply, saturating accumulate, bias add, rounding and result register.
`default_nettype none

module tcb_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tcb_pkg::t_s1                 i_s1,
    input  wire logic [tcb_pkg::DATA_W-1:0]   i_weight,
    output logic                              o_s1_take,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [tcb_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_saturated
);
    import tcb_pkg::*;

    localparam logic signed [ACC_W-16:0] Q_MAX = 49'sh0_7fff_ffff;
    localparam logic signed [ACC_W-16:0] Q_MIN = -49'sh0_8000_0000;

    logic                     r_s2_valid, r_s2_last;
    logic signed [ACC_W-1:0]  r_s2_prod;
    logic signed [DATA_W-1:0] r_s2_bias;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_clamp;
    logic                     r_s3_valid, r_s3_clamp;
    logic [ACC_W-1:0]         r_s3_sum;
    logic signed [DATA_W-1:0] r_s3_bias;
    logic                     r_s4_valid, r_s4_clamp;
    logic [ACC_W-1:0]         r_s4_sum;
    logic                     r_out_valid, r_out_sat;
    logic signed [DATA_W-1:0] r_out_value;

    logic out_free, s4_free, s3_free, s2_free, s2_fire;
    t_sat acc_sum, bias_sum;
    logic [ACC_W-1:0] bias_ext;
    logic signed [ACC_W-16:0] q;
    logic signed [DATA_W-1:0] narrow;
    logic narrow_clamp;

    function automatic t_sat sat_add(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
        t_sat res;
        res.sum   = a + b;
        res.clamp = 1'b0;
        if (!a[ACC_W-1] && !b[ACC_W-1] && res.sum[ACC_W-1]) begin
            res.sum   = {1'b0, {(ACC_W-1){1'b1}}};
            res.clamp = 1'b1;
        end else if (a[ACC_W-1] && b[ACC_W-1] && !res.sum[ACC_W-1]) begin
            res.sum   = {1'b1, {(ACC_W-1){1'b0}}};
            res.clamp = 1'b1;
        end
        return res;
    endfunction

    assign out_free  = !r_out_valid || i_out_ready;
    assign s4_free   = !r_s4_valid || out_free;
    assign s3_free   = !r_s3_valid || s4_free;
    assign s2_free   = !r_s2_valid || !r_s2_last || s3_free;
    assign s2_fire   = r_s2_valid && (!r_s2_last || s3_free);
    assign o_s1_take = i_s1.valid && s2_free;

    assign acc_sum  = sat_add(r_acc, r_s2_prod);
    assign bias_ext = {{(ACC_W-DATA_W-16){r_s3_bias[DATA_W-1]}}, r_s3_bias, 16'h0000};
    assign bias_sum = sat_add(r_s3_sum, bias_ext);

    // round half up to Q16.16, then clamp to 32 bits
    assign q = $signed({r_s4_sum[ACC_W-1], r_s4_sum[ACC_W-1:16]})
             + $signed({{(ACC_W-16){1'b0}}, r_s4_sum[15]});

    always_comb begin
        narrow_clamp = 1'b0;
        narrow       = q[DATA_W-1:0];
        if (q > Q_MAX) begin
            narrow       = {1'b0, {(DATA_W-1){1'b1}}};
            narrow_clamp = 1'b1;
        end else if (q < Q_MIN) begin
            narrow       = {1'b1, {(DATA_W-1){1'b0}}};
            narrow_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_clamp     <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= i_s1.valid;
            end
            if (s2_fire) begin
                if (r_s2_last) begin
                    r_acc   <= '0;
                    r_clamp <= 1'b0;
                end else begin
                    r_acc   <= acc_sum.sum;
                    r_clamp <= r_clamp | acc_sum.clamp;
                end
            end
            if (s3_free) begin
                r_s3_valid <= s2_fire && r_s2_last;
            end
            if (s4_free) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_s2_prod <= $signed(i_weight) * i_s1.elem;
            r_s2_last <= i_s1.last;
            r_s2_bias <= i_s1.bias;
        end
        if (s3_free) begin
            r_s3_sum   <= acc_sum.sum;
            r_s3_clamp <= r_clamp | acc_sum.clamp;
            r_s3_bias  <= r_s2_bias;
        end
        if (s4_free) begin
            r_s4_sum   <= bias_sum.sum;
            r_s4_clamp <= r_s3_clamp | bias_sum.clamp;
        end
        if (out_free) begin
            r_out_value <= narrow;
            r_out_sat   <= r_s4_clamp | narrow_clamp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_saturated    = r_out_sat;

endmodule

`default_nettype wire

// ===== sv/tensor_contract_with_bias.sv =====
// Top level of the tensor contraction with bias block.
// A result reaches o_out_valid through the s1, s2, s3, s4 and result registers.
// Throughput: one request per cycle, loads and elements alike, while a stall does not hold
// o_in_ready low; set by the single multiplier and the 64-bit saturating accumulator stage.
// Reset (synchronous, active low) clears pipeline valids, accumulator, position and
// dimension registers (both 1); the weight store is not cleared.
`default_nettype none

module tensor_contract_with_bias #(
    parameter int MAX_ROWS = tcb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tcb_pkg::MAX_COLS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [tcb_pkg::DIM_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_op,
    input  wire logic [tcb_pkg::ADDR_W-1:0]        i_weight_index,
    input  wire logic signed [tcb_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [tcb_pkg::DATA_W-1:0] i_bias,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [tcb_pkg::DATA_W-1:0]      o_result_value,
    output logic                                   o_saturated
);
    import tcb_pkg::*;

    t_s1               s1;
    logic              s1_take;
    logic              accept;
    logic [DATA_W-1:0] weight;

    assign o_in_ready = !s1.valid || s1_take;
    assign accept     = i_in_valid && o_in_ready;

    tcb_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_weight_index(i_weight_index),
        .i_value       (i_value),
        .i_bias        (i_bias),
        .i_s1_take     (s1_take),
        .o_s1          (s1),
        .o_weight      (weight)
    );

    tcb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1          (s1),
        .i_weight      (weight),
        .o_s1_take     (s1_take),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_value(o_result_value),
        .o_saturated   (o_saturated)
    );

endmodule

`default_nettype wire

// ===== sv/tcb_checker.sv =====
// Port-level checker for the tensor contraction with bias block, with its bind.
`default_nettype none

module tcb_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [tcb_pkg::DATA_W-1:0] o_result_value,
    input wire logic                              o_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_saturated))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_ready)
        else $error("not ready after reset");

    // with the result register empty, no stage can be blocked
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind tensor_contract_with_bias tcb_checker u_tcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_value(o_result_value),
    .o_saturated   (o_saturated)
);

`default_nettype wire
